>>> sv/vrs_pkg.sv
// Package for the variable record stack.
// Holds the operation codes and the command word passed from the front end to the back end.
// No dependencies.
package vrs_pkg;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_PEEK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam int CNT_W = 5;

   typedef struct packed {
      logic [1:0]  op;
      logic        len_bad;
      logic [3:0]  len;
      logic [63:0] data;
   } cmd_type;

endpackage

>>> sv/vrs_front.sv
// Front end of the variable record stack: accepts request words and classifies them.
// Queues up to two commands for the back end.
// Depends on vrs_pkg.
module vrs_front
   import vrs_pkg::*;
#(
   parameter int MAX_RECORD = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_length,
   input  logic [63:0] req_record_data,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_take
);

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push;
   cmd_type    entry;

   always_comb begin
      entry.op      = req_func;
      entry.len     = req_length;
      entry.len_bad = req_length > 4'(MAX_RECORD);
      entry.data    = req_record_data;
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = cmd_take ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= entry;
      end
   end

endmodule

>>> sv/vrs_back.sv
// Back end of the variable record stack: executes commands against the byte store.
// Holds the byte store, the top index, the sequencer and the result register.
// Depends on vrs_pkg.
module vrs_back
   import vrs_pkg::*;
#(
   parameter int CAPACITY     = 1024,
   parameter int MAX_RECORD   = 8,
   parameter int HEADER_BYTES = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [63:0] rsp_read_data,
   output logic [3:0]  rsp_read_len,
   output logic        rsp_is_empty,
   output logic [10:0] rsp_free_bytes
);

   localparam int AW = $clog2(CAPACITY);
   localparam int TW = $clog2(CAPACITY + 1);
   localparam int DW = TW + 1;
   localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
   localparam logic [TW-1:0] HDR_T = TW'(HEADER_BYTES);
   localparam logic [DW-1:0] CAP_D = DW'(CAPACITY);
   localparam logic [DW-1:0] HDR_D = DW'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] HDR_K = CNT_W'(HEADER_BYTES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_HDR   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [7:0]       mem [CAPACITY];
   logic [7:0]       mem_q_ff;
   logic [AW-1:0]    raddr, waddr;
   logic [7:0]       wdata;
   logic             we;

   logic [2:0]       st_ff, st_in;
   logic [TW-1:0]    top_ff, top_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [AW-1:0]    wa_ff, wa_in;
   logic [3:0]       len_ff, len_in;
   logic [63:0]      data_ff, data_in;
   logic [DW-1:0]    dst_ff, dst_in;
   logic             pop_ff, pop_in;
   logic             ok_ff, ok_in;
   logic [63:0]      acc_ff, acc_in;
   logic [3:0]       rlen_ff, rlen_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [2:0]       pidx_ff, pidx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff;
   logic [63:0]      rsp_data_ff;
   logic [3:0]       rsp_len_ff;
   logic             rsp_empty_ff;
   logic [10:0]      rsp_free_ff;
   logic             load;

   logic [TW-1:0]    base;
   logic [2:0]       didx;
   logic [DW-1:0]    dstart, room, stored_d, nt, raddr_d;
   logic [3:0]       hclip, stored;

   always_comb begin
      base     = top_ff - TW'(cmd.len) - HDR_T;
      didx     = 3'(k_ff - HDR_K);
      dstart   = DW'(top_ff) + HDR_D;
      room     = (dstart <= CAP_D) ? (CAP_D - dstart) : '0;
      hclip    = (mem_q_ff > 8'(MAX_RECORD)) ? 4'(MAX_RECORD) : mem_q_ff[3:0];
      stored_d = (DW'(hclip) > room) ? room : DW'(hclip);
      stored   = stored_d[3:0];
      nt       = dstart + stored_d;
      raddr_d  = dst_ff + DW'(cnt_ff);
   end

   always_comb begin
      st_in    = st_ff;
      top_in   = top_ff;
      k_in     = k_ff;
      wa_in    = wa_ff;
      len_in   = len_ff;
      data_in  = data_ff;
      dst_in   = dst_ff;
      pop_in   = pop_ff;
      ok_in    = ok_ff;
      acc_in   = acc_ff;
      rlen_in  = rlen_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      pidx_in  = pidx_ff;
      cmd_take = 1'b0;
      load     = 1'b0;
      we       = 1'b0;
      waddr    = wa_ff;
      wdata    = 8'd0;
      raddr    = top_ff[AW-1:0];
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               acc_in   = 64'd0;
               rlen_in  = 4'd0;
               ok_in    = 1'b0;
               st_in    = ST_FIN;
               case (cmd.op)
                  OP_PUSH: begin
                     if (!cmd.len_bad && (TW'(cmd.len) + HDR_T <= top_ff)) begin
                        wa_in   = base[AW-1:0];
                        dst_in  = DW'(base);
                        k_in    = '0;
                        len_in  = cmd.len;
                        data_in = cmd.data;
                        ok_in   = 1'b1;
                        st_in   = ST_WRITE;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (top_ff < CAP_T) begin
                        pop_in = cmd.op == OP_POP;
                        len_in = cmd.len;
                        ok_in  = 1'b1;
                        st_in  = ST_HDR;
                     end
                  end
                  OP_CLEAR: begin
                     top_in = CAP_T;
                     ok_in  = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            we    = 1'b1;
            wa_in = wa_ff + AW'(1);
            k_in  = k_ff + CNT_W'(1);
            if (k_ff < HDR_K) begin
               wdata = (k_ff == '0) ? 8'(len_ff) : 8'd0;
            end else begin
               wdata = data_ff[8*didx +: 8];
            end
            if (k_ff == HDR_K + CNT_W'(len_ff) - CNT_W'(1)) begin
               top_in = dst_ff[TW-1:0];
               st_in  = ST_FIN;
            end
         end
         ST_HDR: begin
            rlen_in = (stored < len_ff) ? stored : len_ff;
            dst_in  = dstart;
            cnt_in  = 4'd0;
            pend_in = 1'b0;
            if (pop_ff) begin
               top_in = (nt > CAP_D) ? CAP_T : nt[TW-1:0];
            end
            st_in = ST_READ;
         end
         ST_READ: begin
            raddr = raddr_d[AW-1:0];
            if (pend_ff) begin
               acc_in[8*pidx_ff +: 8] = mem_q_ff;
            end
            if (cnt_ff < rlen_ff) begin
               pend_in = 1'b1;
               pidx_in = cnt_ff[2:0];
               cnt_in  = cnt_ff + 4'd1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  st_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load  = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         top_ff       <= CAP_T;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      wa_ff   <= wa_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      dst_ff  <= dst_in;
      pop_ff  <= pop_in;
      ok_ff   <= ok_in;
      acc_ff  <= acc_in;
      rlen_ff <= rlen_in;
      cnt_ff  <= cnt_in;
      pend_ff <= pend_in;
      pidx_ff <= pidx_in;
      if (load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_data_ff  <= acc_ff;
         rsp_len_ff   <= rlen_ff;
         rsp_empty_ff <= top_ff >= CAP_T;
         rsp_free_ff  <= 11'(top_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_read_len   = rsp_len_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_free_bytes = rsp_free_ff;

`ifndef SYNTHESIS
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CAP_T)
      else $error("top index beyond capacity");

   a_write_below_top: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_WRITE |-> TW'(wa_ff) < top_ff)
      else $error("push writes at or above the top index");

   a_read_in_record: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_READ && pend_ff) |-> {1'b0, pidx_ff} < rlen_ff)
      else $error("read captures a byte beyond the delivered length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_len_ff <= 4'(MAX_RECORD))
      else $error("delivered length exceeds the record limit");
`endif

endmodule

>>> sv/variable_record_stack.sv
// Top level of the variable record stack: a LIFO of variable-length records in a byte store.
// Instantiates the front end (request queue) and the back end (sequencer and byte store).
// Depends on vrs_pkg, vrs_front and vrs_back.

// The stack keeps records of up to MAX_RECORD bytes in a byte-wide store of CAPACITY bytes,
// each record topped by a HEADER_BYTES length header, and answers every request word with one
// response word that carries the status, any popped or peeked bytes, the empty flag and the
// free byte count. The byte store moves one byte per cycle: a push writes the header bytes and
// then the record bytes, and a pop or peek reads the length header and then the delivered bytes.
// A two-word queue at the input lets requests arrive while the sequencer is busy, and the
// response register holds a finished word while the next request starts. Reset empties the
// stack; no clearing pass is needed.
module variable_record_stack
   import vrs_pkg::*;
#(
   parameter int CAPACITY     = 1024,
   parameter int MAX_RECORD   = 8,
   parameter int HEADER_BYTES = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_length,
   input  logic [63:0] req_record_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [63:0] rsp_read_data,
   output logic [3:0]  rsp_read_len,
   output logic        rsp_is_empty,
   output logic [10:0] rsp_free_bytes
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   vrs_front #(
      .MAX_RECORD(MAX_RECORD)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_length(req_length),
      .req_record_data(req_record_data),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_take(cmd_take)
   );

   vrs_back #(
      .CAPACITY(CAPACITY),
      .MAX_RECORD(MAX_RECORD),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_take(cmd_take),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_read_data(rsp_read_data),
      .rsp_read_len(rsp_read_len),
      .rsp_is_empty(rsp_is_empty),
      .rsp_free_bytes(rsp_free_bytes)
   );

endmodule

>>> test/testbench.sv
// Self-checking testbench for variable_record_stack: directed, full-store and random pushes,
// pops, peeks and clears, checked word by word against an in-bench model of the byte stack.
// Depends on vrs_pkg and the variable_record_stack RTL.
`timescale 1ns / 1ps

module testbench;
   import vrs_pkg::*;

   localparam int CAPACITY     = 1024;
   localparam int MAX_RECORD   = 8;
   localparam int HEADER_BYTES = 1;
   localparam int SETTLE_CYCLES = 20;
   localparam int STUCK_LIMIT   = 4000;

   typedef struct {
      logic        ok;
      logic [63:0] read_data;
      logic [3:0]  read_len;
      logic        is_empty;
      logic [10:0] free_bytes;
   } stack_reply_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = OP_CLEAR;
   logic [3:0]  req_length = 4'd0;
   logic [63:0] req_record_data = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [63:0] rsp_read_data;
   logic [3:0]  rsp_read_len;
   logic        rsp_is_empty;
   logic [10:0] rsp_free_bytes;

   bit [7:0]     stack_mem [CAPACITY];
   int unsigned  stack_top = CAPACITY;
   stack_reply_t pending_replies [$];
   stack_reply_t next_reply;
   int           mismatches = 0;
   int           stuck_cycles = 0;
   int           idle_pct = 0;
   int           stall_pct = 0;

   variable_record_stack #(
      .CAPACITY    (CAPACITY),
      .MAX_RECORD  (MAX_RECORD),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_length     (req_length),
      .req_record_data(req_record_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .rsp_read_len   (rsp_read_len),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_free_bytes (rsp_free_bytes)
   );

   always #5 clock = ~clock;

   function automatic stack_reply_t stack_predict(input logic [1:0] func, input logic [3:0] len,
                                                  input logic [63:0] data);
      stack_reply_t reply;
      int unsigned  base;
      int unsigned  stored;
      int unsigned  dstart;
      int unsigned  room;
      logic [63:0]  header;
      reply = '{ok: 1'b0, read_data: 64'd0, read_len: 4'd0, is_empty: 1'b0, free_bytes: 11'd0};
      if (func == OP_PUSH) begin
         if (len <= MAX_RECORD && len + HEADER_BYTES <= stack_top) begin
            base = stack_top - len - HEADER_BYTES;
            for (int i = 0; i < HEADER_BYTES; i++) begin
               stack_mem[base + i] = (i < 8) ? 8'(64'(len) >> (8 * i)) : 8'd0;
            end
            for (int i = 0; i < len; i++) begin
               stack_mem[base + HEADER_BYTES + i] = data[8 * i +: 8];
            end
            stack_top = base;
            reply.ok = 1'b1;
         end
      end else if (func == OP_POP || func == OP_PEEK) begin
         if (stack_top < CAPACITY) begin
            header = 64'd0;
            for (int i = 0; i < HEADER_BYTES && i < 8; i++) begin
               if (stack_top + i < CAPACITY) begin
                  header |= 64'(stack_mem[stack_top + i]) << (8 * i);
               end
            end
            stored = (header > MAX_RECORD) ? MAX_RECORD : int'(header);
            dstart = stack_top + HEADER_BYTES;
            room = (dstart <= CAPACITY) ? CAPACITY - dstart : 0;
            if (stored > room) begin
               stored = room;
            end
            reply.read_len = 4'((stored < len) ? stored : len);
            for (int i = 0; i < reply.read_len; i++) begin
               reply.read_data[8 * i +: 8] = stack_mem[dstart + i];
            end
            if (func == OP_POP) begin
               stack_top = (dstart + stored > CAPACITY) ? CAPACITY : dstart + stored;
            end
            reply.ok = 1'b1;
         end
      end else begin
         stack_top = CAPACITY;
         reply.ok = 1'b1;
      end
      reply.is_empty = (stack_top >= CAPACITY);
      reply.free_bytes = 11'(stack_top);
      return reply;
   endfunction

   task automatic send_word(input logic [1:0] func, input logic [3:0] len,
                            input logic [63:0] data);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_length <= len;
      req_record_data <= data;
      do @(negedge clock); while (req_stall !== 1'b0);
      pending_replies.push_back(stack_predict(func, len, data));
      @(posedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_replies.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
         end else begin
            next_reply = pending_replies.pop_front();
            check_field("ok", 64'(next_reply.ok), 64'(rsp_ok));
            check_field("read_data", next_reply.read_data, rsp_read_data);
            check_field("read_len", 64'(next_reply.read_len), 64'(rsp_read_len));
            check_field("is_empty", 64'(next_reply.is_empty), 64'(rsp_is_empty));
            check_field("free_bytes", 64'(next_reply.free_bytes), 64'(rsp_free_bytes));
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_word(OP_POP, 4'd8, 64'd0);
      send_word(OP_PEEK, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_CLEAR, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_PUSH, 4'd0, 64'hDEAD_BEEF_0123_4567);
      send_word(OP_PEEK, 4'd15, 64'd0);
      send_word(OP_POP, 4'd0, 64'd0);
      send_word(OP_PUSH, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_PEEK, 4'd3, 64'd0);
      send_word(OP_PEEK, 4'd15, 64'd0);
      send_word(OP_PUSH, 4'd8, 64'd0);
      send_word(OP_PUSH, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_PUSH, 4'd9, 64'h0F1E_2D3C_4B5A_6978);
      send_word(OP_POP, 4'd8, 64'd0);
      send_word(OP_POP, 4'd4, 64'd0);
      send_word(OP_PUSH, 4'd5, 64'hA5A5_A5A5_A5A5_A5A5);
      send_word(OP_PUSH, 4'd1, 64'h5A5A_5A5A_5A5A_5A5A);
      send_word(OP_CLEAR, 4'd0, 64'd0);
      send_word(OP_POP, 4'd8, 64'd0);
      send_word(OP_PUSH, 4'd3, {$urandom, $urandom});
      send_word(OP_PEEK, 4'd8, 64'd0);
      send_word(OP_POP, 4'd15, 64'd0);
   endtask

   task automatic test_full_store();
      int room;
      while (stack_top >= MAX_RECORD + HEADER_BYTES) begin
         send_word(OP_PUSH, 4'($urandom_range(MAX_RECORD)), {$urandom, $urandom});
      end
      room = stack_top;
      send_word(OP_PUSH, 4'(room), {$urandom, $urandom});
      if (room >= HEADER_BYTES) begin
         send_word(OP_PUSH, 4'(room - HEADER_BYTES), {$urandom, $urandom});
      end
      send_word(OP_PUSH, 4'd0, {$urandom, $urandom});
      send_word(OP_PEEK, 4'd8, 64'd0);
      send_word(OP_POP, 4'd15, 64'd0);
   endtask

   task automatic test_random(input int count, input int sender_idle, input int receiver_stall);
      int push_lim;
      int pop_lim;
      int peek_lim;
      int roll;
      int drain_at;
      logic [1:0] func;
      logic [3:0] len;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      drain_at = $urandom_range(count - 1);
      push_lim = 45;
      pop_lim = 75;
      peek_lim = 97;
      for (int n = 0; n < count; n++) begin
         if (n % 128 == 0) begin
            case ($urandom_range(2))
               0: begin
                  push_lim = 80; pop_lim = 90; peek_lim = 99;
               end
               1: begin
                  push_lim = 45; pop_lim = 75; peek_lim = 97;
               end
               default: begin
                  push_lim = 20; pop_lim = 75; peek_lim = 97;
               end
            endcase
         end
         if (n == drain_at) begin
            wait_drain();
         end
         roll = $urandom_range(99);
         if (roll < push_lim) begin
            func = OP_PUSH;
            len = ($urandom_range(99) < 10) ? 4'($urandom_range(15, MAX_RECORD + 1))
                                            : 4'($urandom_range(MAX_RECORD));
         end else begin
            func = (roll < pop_lim) ? OP_POP : (roll < peek_lim) ? OP_PEEK : OP_CLEAR;
            roll = $urandom_range(99);
            len = (roll < 60) ? 4'($urandom_range(MAX_RECORD)) :
                  (roll < 80) ? 4'(MAX_RECORD) : 4'($urandom_range(15, MAX_RECORD + 1));
         end
         send_word(func, len, {$urandom, $urandom});
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random(500, 0, 0);
      test_random(500, 50, 0);
      test_random(500, 0, 50);
      test_random(500, 9, 9);
      idle_pct = 0;
      stall_pct = 0;
      wait_drain();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
